/* rtl/bba_pkg.sv */
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    // Map geometry and request split.
    localparam int MAP_WORDS_DEF = 64;
    localparam int WORD_BITS     = 64;
    localparam int SMALL_LIMIT   = 32;

    // Configuration register reset values.
    localparam logic [63:0] BASE_RST  = 64'd0;
    localparam logic [5:0]  SHIFT_RST = 6'd12;
    localparam logic [12:0] TOTAL_RST = 13'd4096;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_SHIFT = 2'd1;
    localparam logic [1:0] CFG_TOTAL = 2'd2;

    // Bits of the op field: byte count and free request.
    localparam int OP_BYTES_BIT = 0;
    localparam int OP_FREE_BIT  = 1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_PREP,
        ST_DISP,
        ST_SRD,
        ST_SEV,
        ST_SIT,
        ST_SPICK,
        ST_LRD,
        ST_LEV,
        ST_LMARK,
        ST_FCHK,
        ST_FRD,
        ST_FWR,
        ST_SHIFT,
        ST_ADD,
        ST_EMIT
    } t_state;

endpackage

/* rtl/bba_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bitmap_block_allocator_core.sv */
// Top level: first-fit bitmap block allocator with a word-serial map scanner.
// Setup (PREP, DISP), the walk, then shift, add and emit; a miss or a free only emits.
// Small alloc: each word is read (SRD, SEV), then each open word gets window steps and a pick.
// Large alloc: each scanned word is read (LRD, LEV), plus one write per word marked.
// Free: a range check, then a read and a write per word touched. One item at a time.
// Reset: synchronous; a clearing pass (ST_CLR) zeroes every map word before input is taken.
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_amount,
    input  logic [63:0] i_free_address,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [63:0] o_block_address,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int WI = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC = $clog2(MAP_WORDS + 1);
    localparam int RW = WC + 1;
    localparam int BW = WI + 6;
    localparam logic [63:0] MAP_BITS  = 64'(MAP_WORDS) << 6;
    localparam logic [WI-1:0] LAST_WORD = WI'(MAP_WORDS - 1);
    localparam logic [63:0] ONES = '1;

    // Configuration registers
    logic [63:0] r_base;
    logic [5:0]  r_shift;
    logic [12:0] r_total;

    // Sequencer and datapath registers
    t_state       r_state, n_state;
    logic [1:0]   r_op;
    logic [63:0]  r_n;
    logic [63:0]  r_fs;
    logic [WI-1:0] r_word;
    logic [63:0]  r_raw;
    logic [63:0]  r_zs;
    logic [63:0]  r_avail;
    logic [4:0]   r_k;
    logic [WC-1:0] r_words;
    logic [WC-1:0] r_run_len;
    logic [WI-1:0] r_run_start;
    logic [WC-1:0] r_left;
    logic [BW-1:0] r_fsb;
    logic [BW-1:0] r_fem1;
    logic [63:0]  r_mask;
    logic [BW-1:0] r_blk;
    logic         r_res_ok;
    logic [63:0]  r_res_addr;
    logic         r_out_valid;
    logic         r_ok;
    logic [63:0]  r_addr;

    // RAM port signals
    logic          ram_we;
    logic [63:0]   ram_wdata;
    logic [63:0]   ram_rdata;

    // Shared combinational terms
    logic          in_acc;
    logic          out_free;
    logic [63:0]   rsv;
    logic [63:0]   word_v;
    logic          word_full;
    logic          word_zero;
    logic          is_last;
    logic [4:0]    n5;
    logic [63:0]   smask;
    logic [5:0]    pick;
    logic          small_done;
    logic          run_hit;
    logic          run_nofit;
    logic [63:0]   words_full;
    logic [63:0]   free_room;
    logic [WI-1:0] fs_word;
    logic [WI-1:0] fe_word;
    logic [5:0]    lo_bit;
    logic [63:0]   hi_mask;

    bba_ram #(
        .WIDTH (64),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (r_word),
        .o_rdata (ram_rdata)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = (r_word == LAST_WORD);
    assign n5       = r_n[4:0];

    // Blocks at or above total_blocks read as used.
    always_comb begin
        if (32'(r_word) < 32'(r_total[12:6])) begin
            rsv = '0;
        end else if (32'(r_word) == 32'(r_total[12:6])) begin
            rsv = ~((64'd1 << r_total[5:0]) - 64'd1);
        end else begin
            rsv = ONES;
        end
    end

    assign word_v    = ram_rdata | rsv;
    assign word_full = (word_v == ONES);
    assign word_zero = (word_v == '0);

    // Small window mask and lowest free window position.
    assign smask = (64'd1 << n5) - 64'd1;
    always_comb begin
        pick = '0;
        for (int b = 63; b >= 0; b--) begin
            if (r_avail[b]) begin
                pick = 6'(b);
            end
        end
    end
    assign small_done = (r_k >= n5);

    // Run tracking for large requests.
    assign run_hit   = ((r_run_len + WC'(1)) == r_words);
    assign run_nofit = (RW'(r_word) + RW'(r_words) + RW'(1)) > RW'(MAP_WORDS);
    assign words_full = (r_n + 64'd63) >> 6;

    // Free range: per-word clear mask.
    assign free_room = MAP_BITS - r_fs;
    assign fs_word   = r_fsb[BW-1:6];
    assign fe_word   = r_fem1[BW-1:6];
    assign lo_bit    = (r_word == fs_word) ? r_fsb[5:0] : 6'd0;
    assign hi_mask   = (r_word == fe_word) ? (ONES >> (6'd63 - r_fem1[5:0])) : ONES;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:   if (is_last) begin
                n_state = ST_IDLE;
            end
            ST_IDLE:  if (i_in_valid) begin
                n_state = ST_PREP;
            end
            ST_PREP:  n_state = ST_DISP;
            ST_DISP: begin
                if (r_op[OP_FREE_BIT]) begin
                    n_state = ST_FCHK;
                end else if (r_n > MAP_BITS) begin
                    n_state = ST_EMIT;
                end else if (r_n >= 64'(SMALL_LIMIT)) begin
                    n_state = ST_LRD;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_SRD:   n_state = ST_SEV;
            ST_SEV: begin
                if (!word_full) begin
                    n_state = ST_SIT;
                end else if (is_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_SIT:   if (small_done) begin
                n_state = ST_SPICK;
            end
            ST_SPICK: begin
                if (r_avail != '0) begin
                    n_state = ST_SHIFT;
                end else if (is_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_LRD:   n_state = ST_LEV;
            ST_LEV: begin
                if (word_zero && run_hit) begin
                    n_state = ST_LMARK;
                end else if (is_last || (!word_zero && run_nofit)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_LRD;
                end
            end
            ST_LMARK: if (r_left == WC'(1)) begin
                n_state = ST_SHIFT;
            end
            ST_FCHK: begin
                if (r_fs >= MAP_BITS || r_n == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_FRD;
                end
            end
            ST_FRD:   n_state = ST_FWR;
            ST_FWR: begin
                if (r_word == fe_word) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_FRD;
                end
            end
            ST_SHIFT: n_state = ST_ADD;
            ST_ADD:   n_state = ST_EMIT;
            ST_EMIT:  if (out_free) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: map write port and input stall.
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_SPICK: begin
                ram_we    = (r_avail != '0);
                ram_wdata = r_raw | (smask << pick);
            end
            ST_LMARK: begin
                ram_we    = 1'b1;
                ram_wdata = ONES;
            end
            ST_FWR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~r_mask;
            end
            default: begin
                ram_we    = 1'b0;
                ram_wdata = '0;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_base  <= BASE_RST;
            r_shift <= SHIFT_RST;
            r_total <= TOTAL_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_SHIFT: r_shift <= i_cfg_data[5:0];
                    CFG_TOTAL: r_total <= i_cfg_data[12:0];
                    default:   ;
                endcase
            end
        end
    end

    // Word pointer: swept by the clearing pass, then by each scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            unique case (r_state)
                ST_CLR:   r_word <= r_word + WI'(1);
                ST_DISP:  r_word <= '0;
                ST_SEV:   if (word_full) begin
                    r_word <= r_word + WI'(1);
                end
                ST_SPICK: if (r_avail == '0) begin
                    r_word <= r_word + WI'(1);
                end
                ST_LEV: begin
                    if (word_zero && run_hit) begin
                        r_word <= r_run_start;
                    end else begin
                        r_word <= r_word + WI'(1);
                    end
                end
                ST_LMARK: r_word <= r_word + WI'(1);
                ST_FCHK:  r_word <= r_fs[BW-1:6];
                ST_FWR:   r_word <= r_word + WI'(1);
                default:  ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op <= i_op;
                r_n  <= i_amount;
                r_fs <= i_free_address;
            end
            ST_PREP: begin
                if (r_op[OP_BYTES_BIT]) begin
                    r_n <= r_n >> r_shift;
                end
                r_fs <= r_fs - r_base;
            end
            ST_DISP: begin
                r_fs        <= r_fs >> r_shift;
                r_words     <= words_full[WC-1:0];
                r_run_len   <= '0;
                r_run_start <= '0;
                r_res_ok    <= !r_op[OP_FREE_BIT] && (r_n <= MAP_BITS);
                r_res_addr  <= '0;
            end
            ST_SEV: begin
                r_raw   <= ram_rdata;
                r_zs    <= ~word_v;
                r_avail <= (n5 == 5'd0) ? ONES : ~word_v;
                r_k     <= 5'd1;
                if (word_full && is_last) begin
                    r_res_ok <= 1'b0;
                end
            end
            ST_SIT: begin
                if (!small_done) begin
                    r_zs    <= r_zs >> 1;
                    r_avail <= r_avail & (r_zs >> 1);
                    r_k     <= r_k + 5'd1;
                end
            end
            ST_SPICK: begin
                r_blk <= {r_word, pick};
                if (r_avail == '0 && is_last) begin
                    r_res_ok <= 1'b0;
                end
            end
            ST_LEV: begin
                if (word_zero) begin
                    r_run_len <= r_run_len + WC'(1);
                    if (run_hit) begin
                        r_left <= r_words;
                    end else if (is_last) begin
                        r_res_ok <= 1'b0;
                    end
                end else begin
                    r_run_len   <= '0;
                    r_run_start <= r_word + WI'(1);
                    if (run_nofit || is_last) begin
                        r_res_ok <= 1'b0;
                    end
                end
            end
            ST_LMARK: begin
                r_left <= r_left - WC'(1);
                r_blk  <= {r_run_start, 6'd0};
            end
            ST_FCHK: begin
                r_res_ok <= 1'b1;
                r_fsb    <= r_fs[BW-1:0];
                if (r_n >= free_room) begin
                    r_fem1 <= BW'(MAP_BITS - 64'd1);
                end else begin
                    r_fem1 <= BW'(r_fs + r_n - 64'd1);
                end
            end
            ST_FRD: begin
                r_mask <= (ONES << lo_bit) & hi_mask;
            end
            ST_SHIFT: begin
                r_res_addr <= 64'(r_blk) << r_shift;
            end
            ST_ADD: begin
                r_res_addr <= r_base + r_res_addr;
                r_res_ok   <= 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: loads once the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_ok   <= r_res_ok;
            r_addr <= r_res_ok ? r_res_addr : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_block_address = r_addr;

    // An accepted item always starts the setup step.
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_PREP))
        else $error("accepted item did not enter setup");

    // A failed allocation never reports an address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_block_address == '0))
        else $error("failed allocation carries an address");

    // A waiting result is held back until the output register frees up.
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !out_free) |=> (r_state == ST_EMIT))
        else $error("result left before output register was free");

    // Marking a run never runs past its word count.
    a_mark_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LMARK) |-> (r_left != '0))
        else $error("run marking underflowed");

endmodule
